[sv/cpuls_pkg.sv]
package cpuls_pkg;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  localparam logic [3:0] OP_LDA = 4'd0;
  localparam logic [3:0] OP_LDX = 4'd1;
  localparam logic [3:0] OP_LDY = 4'd2;
  localparam logic [3:0] OP_STA = 4'd3;
  localparam logic [3:0] OP_STX = 4'd4;
  localparam logic [3:0] OP_STY = 4'd5;
  localparam logic [3:0] OP_TAX = 4'd6;
  localparam logic [3:0] OP_TXA = 4'd7;
  localparam logic [3:0] OP_TAY = 4'd8;
  localparam logic [3:0] OP_TYA = 4'd9;
  localparam logic [3:0] OP_TSX = 4'd10;
  localparam logic [3:0] OP_TXS = 4'd11;

  localparam logic [3:0] MODE_IMP  = 4'd0;
  localparam logic [3:0] MODE_IMM  = 4'd1;
  localparam logic [3:0] MODE_ZP   = 4'd2;
  localparam logic [3:0] MODE_ZPX  = 4'd3;
  localparam logic [3:0] MODE_ZPY  = 4'd4;
  localparam logic [3:0] MODE_ABS  = 4'd5;
  localparam logic [3:0] MODE_ABSX = 4'd6;
  localparam logic [3:0] MODE_ABSY = 4'd7;
  localparam logic [3:0] MODE_INDX = 4'd8;
  localparam logic [3:0] MODE_INDY = 4'd9;

  localparam logic [1:0] BUS_NONE  = 2'd0;
  localparam logic [1:0] BUS_READ  = 2'd1;
  localparam logic [1:0] BUS_WRITE = 2'd2;

  localparam logic [15:0] PAGE_MASK = 16'hFF00;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_PTR_LO = 2'd1,
    PH_PTR_HI = 2'd2,
    PH_LOAD   = 2'd3
  } phase_t;

  typedef struct packed {
    logic       command;
    logic [3:0] operation;
    logic [3:0] address_mode;
    logic [7:0] operand_low;
    logic [7:0] operand_high;
    logic [7:0] read_data;
  } step_t;

  typedef struct packed {
    logic [1:0]  bus_action;
    logic [15:0] bus_address;
    logic [7:0]  bus_write_data;
    logic        instruction_done;
    logic [2:0]  ticks_used;
    logic [7:0]  accumulator_out;
    logic [7:0]  x_out;
    logic [7:0]  y_out;
    logic [7:0]  stack_out;
    logic        zero_out;
    logic        negative_out;
  } report_t;

  typedef struct packed {
    logic [7:0] accumulator;
    logic [7:0] index_x;
    logic [7:0] index_y;
    logic [7:0] stack_pointer;
    logic       zero_flag;
    logic       negative_flag;
    phase_t     phase;
    logic [3:0] held_operation;
    logic [3:0] held_mode;
    logic [7:0] pointer_byte;
    logic [7:0] address_low;
    logic       penalty_tick;
  } arch_t;

  function automatic logic is_load(input logic [3:0] op);
    return op <= OP_LDY;
  endfunction

  function automatic logic pair_ok(input logic [3:0] op, input logic [3:0] mode);
    logic ok;
    ok = 1'b0;
    case (op)
      OP_LDA: ok = mode >= MODE_IMM && mode <= MODE_INDY && mode != MODE_ZPY;
      OP_LDX: ok = mode == MODE_IMM || mode == MODE_ZP || mode == MODE_ZPY ||
                   mode == MODE_ABS || mode == MODE_ABSY;
      OP_LDY: ok = mode == MODE_IMM || mode == MODE_ZP || mode == MODE_ZPX ||
                   mode == MODE_ABS || mode == MODE_ABSX;
      OP_STA: ok = mode >= MODE_ZP && mode <= MODE_INDY && mode != MODE_ZPY;
      OP_STX: ok = mode == MODE_ZP || mode == MODE_ZPY || mode == MODE_ABS;
      OP_STY: ok = mode == MODE_ZP || mode == MODE_ZPX || mode == MODE_ABS;
      default: ok = op <= OP_TXS && mode == MODE_IMP;
    endcase
    return ok;
  endfunction

  function automatic logic [2:0] tick_count(input logic [3:0] mode, input logic pen);
    logic [2:0] t;
    case (mode) inside
      MODE_IMM:                     t = 3'd1;
      MODE_ZP:                      t = 3'd2;
      MODE_ZPX, MODE_ZPY, MODE_ABS: t = 3'd3;
      MODE_ABSX, MODE_ABSY:         t = 3'd3 + {2'b00, pen};
      MODE_INDX:                    t = 3'd5;
      MODE_INDY:                    t = 3'd4 + {2'b00, pen};
      default:                      t = 3'd1;
    endcase
    return t;
  endfunction

endpackage

[sv/cpuls_if.sv]
interface cpuls_step_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [3:0] operation;
  logic [3:0] address_mode;
  logic [7:0] operand_low;
  logic [7:0] operand_high;
  logic [7:0] read_data;

  modport source (
    output valid, command, operation, address_mode, operand_low, operand_high, read_data,
    input  ready
  );
  modport sink (
    input  valid, command, operation, address_mode, operand_low, operand_high, read_data,
    output ready
  );
endinterface

interface cpuls_report_if;
  logic        valid;
  logic        ready;
  logic [1:0]  bus_action;
  logic [15:0] bus_address;
  logic [7:0]  bus_write_data;
  logic        instruction_done;
  logic [2:0]  ticks_used;
  logic [7:0]  accumulator_out;
  logic [7:0]  x_out;
  logic [7:0]  y_out;
  logic [7:0]  stack_out;
  logic        zero_out;
  logic        negative_out;

  modport source (
    output valid, bus_action, bus_address, bus_write_data, instruction_done, ticks_used,
           accumulator_out, x_out, y_out, stack_out, zero_out, negative_out,
    input  ready
  );
  modport sink (
    input  valid, bus_action, bus_address, bus_write_data, instruction_done, ticks_used,
           accumulator_out, x_out, y_out, stack_out, zero_out, negative_out,
    output ready
  );
endinterface

[sv/cpuls_exec.sv]
module cpuls_exec import cpuls_pkg::*; (
  input  arch_t   st,
  input  step_t   stp,
  output arch_t   st_next,
  output report_t res
);

  logic        start;
  logic        ok;
  logic [3:0]  fin_op;
  logic [3:0]  fin_mode;
  logic [15:0] base_abs;
  logic [15:0] base_ind;
  logic [15:0] ibase;
  logic [7:0]  idx_sel;
  logic [15:0] isum;
  logic        pen_idx;
  logic [7:0]  zp_off;
  logic [7:0]  zp_sum;
  logic [7:0]  store_val;
  phase_t      phase_next;

  assign start    = stp.command == CMD_START;
  assign ok       = pair_ok(stp.operation, stp.address_mode);
  assign fin_op   = start ? stp.operation : st.held_operation;
  assign fin_mode = start ? stp.address_mode : st.held_mode;
  assign base_abs = {stp.operand_high, stp.operand_low};
  assign base_ind = {stp.read_data, st.address_low};
  assign ibase    = start ? base_abs : base_ind;
  assign idx_sel  = (start && stp.address_mode == MODE_ABSX) ? st.index_x : st.index_y;
  assign isum     = ibase + {8'h00, idx_sel};
  assign pen_idx  = ((ibase & PAGE_MASK) != (isum & PAGE_MASK)) || fin_op == OP_STA;
  assign zp_off   = (stp.address_mode == MODE_ZPX) ? st.index_x :
                    (stp.address_mode == MODE_ZPY) ? st.index_y : 8'h00;
  assign zp_sum   = stp.operand_low + zp_off;

  always_comb begin
    case (fin_op)
      OP_STA:  store_val = st.accumulator;
      OP_STX:  store_val = st.index_x;
      default: store_val = st.index_y;
    endcase
  end

  // phase sequencing
  always_comb begin
    phase_next = st.phase;
    if (start) begin
      phase_next = PH_IDLE;
      if (ok) begin
        case (stp.address_mode) inside
          MODE_ZP, MODE_ZPX, MODE_ZPY, MODE_ABS, MODE_ABSX, MODE_ABSY: begin
            phase_next = is_load(stp.operation) ? PH_LOAD : PH_IDLE;
          end
          MODE_INDX, MODE_INDY: phase_next = PH_PTR_LO;
          default:              phase_next = PH_IDLE;
        endcase
      end
    end else begin
      unique case (st.phase)
        PH_PTR_LO: phase_next = PH_PTR_HI;
        PH_PTR_HI: phase_next = is_load(st.held_operation) ? PH_LOAD : PH_IDLE;
        PH_LOAD:   phase_next = PH_IDLE;
        default:   phase_next = PH_IDLE;
      endcase
    end
  end

  // datapath and result
  always_comb begin
    arch_t       nx;
    report_t     rs;
    logic        fire;
    logic [15:0] ea;
    logic        ld_en;
    logic [3:0]  ld_op;
    logic [7:0]  ld_val;
    logic        fl_en;
    logic [7:0]  fl_val;

    nx     = st;
    rs     = '0;
    fire   = 1'b0;
    ea     = '0;
    ld_en  = 1'b0;
    ld_op  = fin_op;
    ld_val = stp.read_data;
    fl_en  = 1'b0;
    fl_val = '0;
    nx.phase = phase_next;

    if (start) begin
      nx.penalty_tick = 1'b0;
      rs.instruction_done = 1'b1;
      if (ok) begin
        nx.held_operation = stp.operation;
        nx.held_mode      = stp.address_mode;
        rs.instruction_done = 1'b0;
        case (stp.address_mode) inside
          MODE_IMP: begin
            rs.instruction_done = 1'b1;
            rs.ticks_used       = 3'd1;
            case (stp.operation)
              OP_TAX: begin nx.index_x = st.accumulator; fl_en = 1'b1; fl_val = st.accumulator; end
              OP_TXA: begin nx.accumulator = st.index_x; fl_en = 1'b1; fl_val = st.index_x; end
              OP_TAY: begin nx.index_y = st.accumulator; fl_en = 1'b1; fl_val = st.accumulator; end
              OP_TYA: begin nx.accumulator = st.index_y; fl_en = 1'b1; fl_val = st.index_y; end
              OP_TSX: begin nx.index_x = st.stack_pointer; fl_en = 1'b1; fl_val = st.stack_pointer; end
              default: nx.stack_pointer = st.index_x;
            endcase
          end
          MODE_IMM: begin
            rs.instruction_done = 1'b1;
            rs.ticks_used       = 3'd1;
            ld_en  = 1'b1;
            ld_val = stp.operand_low;
          end
          MODE_ZP: begin
            fire = 1'b1;
            ea   = {8'h00, stp.operand_low};
          end
          MODE_ZPX, MODE_ZPY: begin
            fire = 1'b1;
            ea   = {8'h00, zp_sum};
          end
          MODE_ABS: begin
            fire = 1'b1;
            ea   = base_abs;
          end
          MODE_ABSX, MODE_ABSY: begin
            fire = 1'b1;
            ea   = isum;
            nx.penalty_tick = pen_idx;
          end
          default: begin
            nx.pointer_byte = (stp.address_mode == MODE_INDX) ?
                              stp.operand_low + st.index_x : stp.operand_low;
            rs.bus_action  = BUS_READ;
            rs.bus_address = {8'h00, nx.pointer_byte};
          end
        endcase
      end
    end else begin
      unique case (st.phase)
        PH_PTR_LO: begin
          nx.address_low  = stp.read_data;
          nx.pointer_byte = st.pointer_byte + 8'd1;
          rs.bus_action   = BUS_READ;
          rs.bus_address  = {8'h00, nx.pointer_byte};
        end
        PH_PTR_HI: begin
          fire = 1'b1;
          if (st.held_mode == MODE_INDY) begin
            ea = isum;
            nx.penalty_tick = pen_idx;
          end else begin
            ea = base_ind;
          end
        end
        PH_LOAD: begin
          ld_en = 1'b1;
          rs.instruction_done = 1'b1;
          rs.ticks_used       = tick_count(st.held_mode, st.penalty_tick);
        end
        default: ;
      endcase
    end

    if (fire) begin
      rs.bus_address = ea;
      if (is_load(fin_op)) begin
        rs.bus_action = BUS_READ;
      end else begin
        rs.bus_action       = BUS_WRITE;
        rs.bus_write_data   = store_val;
        rs.instruction_done = 1'b1;
        rs.ticks_used       = tick_count(fin_mode, nx.penalty_tick);
      end
    end

    if (ld_en) begin
      case (ld_op)
        OP_LDA:  nx.accumulator = ld_val;
        OP_LDX:  nx.index_x     = ld_val;
        default: nx.index_y     = ld_val;
      endcase
      fl_en  = 1'b1;
      fl_val = ld_val;
    end

    if (fl_en) begin
      nx.zero_flag     = fl_val == 8'h00;
      nx.negative_flag = fl_val[7];
    end

    rs.accumulator_out = nx.accumulator;
    rs.x_out           = nx.index_x;
    rs.y_out           = nx.index_y;
    rs.stack_out       = nx.stack_pointer;
    rs.zero_out        = nx.zero_flag;
    rs.negative_out    = nx.negative_flag;

    st_next = nx;
    res     = rs;
  end

endmodule

[sv/cpuls_regs.sv]
module cpuls_regs import cpuls_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  advance,
  input  arch_t st_next,
  output arch_t st
);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

endmodule

[sv/cpu6502_load_store_transfer.sv]
// 6502 load, store and register-transfer unit.
// step channel: each item either starts an instruction (command 0, with
// operation, addressing mode and operand bytes) or returns the byte for the
// read request of the previous report (command 1).
// report channel: exactly one item per step item, in order, carrying the bus
// request for that step, the done flag with the tick count, and the
// registers and flags as they stand after the step.
// a step item is held in the input register, then in the output register,
// from which it is offered as a report item. throughput: one item per
// cycle unless the report channel stalls; the execute logic sits between
// the input and output registers, and the architectural registers update
// as an item moves across, so the next item sees them at once.
// a stalled report channel holds its item; one more step item can wait in
// the input register, after which step.ready falls until report.ready rises.
// reset (rst, synchronous) clears A, X, Y, S, the flags and all pending
// instruction state, and empties both registers.
module cpu6502_load_store_transfer import cpuls_pkg::*; (
  input logic            clk,
  input logic            rst,
  cpuls_step_if.sink     step,
  cpuls_report_if.source report
);

  logic    in_valid;
  step_t   in_item;
  logic    out_valid;
  report_t out_item;
  logic    advance;
  arch_t   st;
  arch_t   st_next;
  report_t res;

  assign advance    = in_valid && (!out_valid || report.ready);
  assign step.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (step.ready) begin
      in_valid <= step.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step.ready && step.valid) begin
      in_item.command      <= step.command;
      in_item.operation    <= step.operation;
      in_item.address_mode <= step.address_mode;
      in_item.operand_low  <= step.operand_low;
      in_item.operand_high <= step.operand_high;
      in_item.read_data    <= step.read_data;
    end
  end

  cpuls_exec u_exec (
    .st      (st),
    .stp     (in_item),
    .st_next (st_next),
    .res     (res)
  );

  cpuls_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .st_next (st_next),
    .st      (st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= res;
    end
  end

  assign report.valid            = out_valid;
  assign report.bus_action       = out_item.bus_action;
  assign report.bus_address      = out_item.bus_address;
  assign report.bus_write_data   = out_item.bus_write_data;
  assign report.instruction_done = out_item.instruction_done;
  assign report.ticks_used       = out_item.ticks_used;
  assign report.accumulator_out  = out_item.accumulator_out;
  assign report.x_out            = out_item.x_out;
  assign report.y_out            = out_item.y_out;
  assign report.stack_out        = out_item.stack_out;
  assign report.zero_out         = out_item.zero_out;
  assign report.negative_out     = out_item.negative_out;

endmodule

[test/tb_cpu6502_load_store_transfer.sv]
`timescale 1ns / 1ps

module tb_cpu6502_load_store_transfer;
  import cpuls_pkg::*;

  localparam int RANDOM_ITEMS = 850;
  localparam int QUIET_TAIL   = 120;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  cpuls_step_if   step_ch ();
  cpuls_report_if report_ch ();

  cpu6502_load_store_transfer uut (
    .clk    (clk),
    .rst    (rst),
    .step   (step_ch),
    .report (report_ch)
  );

  step_t   pending_steps[$];
  report_t expected_reports[$];
  step_t   on_bus;
  report_t got, want;

  int steps_planned;
  int steps_taken;
  int failures;
  int quiet_cycles;
  int send_gap;
  int hold_gap;
  int owed_bytes;
  int useful_items;

  // predicted cpu state
  logic [7:0] reg_a, reg_x, reg_y, reg_s;
  logic       flag_z, flag_n;
  phase_t     seq_phase;
  logic [3:0] held_op, held_mode;
  logic [7:0] ptr_addr, ptr_low;
  logic       extra_tick;

  function automatic bit legal_pair(input logic [3:0] op, input logic [3:0] mode);
    case (op)
      OP_LDA: return mode != MODE_IMP && mode != MODE_ZPY && mode <= MODE_INDY;
      OP_STA: return mode > MODE_IMM && mode != MODE_ZPY && mode <= MODE_INDY;
      OP_LDX: return mode == MODE_IMM || mode == MODE_ZP || mode == MODE_ZPY ||
                     mode == MODE_ABS || mode == MODE_ABSY;
      OP_LDY: return mode == MODE_IMM || mode == MODE_ZP || mode == MODE_ZPX ||
                     mode == MODE_ABS || mode == MODE_ABSX;
      OP_STX: return mode == MODE_ZP || mode == MODE_ZPY || mode == MODE_ABS;
      OP_STY: return mode == MODE_ZP || mode == MODE_ZPX || mode == MODE_ABS;
      OP_TAX, OP_TXA, OP_TAY, OP_TYA, OP_TSX, OP_TXS: return mode == MODE_IMP;
      default: return 1'b0;
    endcase
  endfunction

  // read-data items an instruction waits for after its start item
  function automatic int data_needed(input logic [3:0] op, input logic [3:0] mode);
    if (!legal_pair(op, mode) || mode == MODE_IMP || mode == MODE_IMM) return 0;
    if (mode == MODE_INDX || mode == MODE_INDY) return (op <= OP_LDY) ? 3 : 2;
    return (op <= OP_LDY) ? 1 : 0;
  endfunction

  function automatic logic [2:0] cycle_count(input logic [3:0] mode, input logic pen);
    case (mode)
      MODE_IMM:                     return 3'd1;
      MODE_ZP:                      return 3'd2;
      MODE_ZPX, MODE_ZPY, MODE_ABS: return 3'd3;
      MODE_ABSX, MODE_ABSY:         return pen ? 3'd4 : 3'd3;
      MODE_INDX:                    return 3'd5;
      MODE_INDY:                    return pen ? 3'd5 : 3'd4;
      default:                      return 3'd1;
    endcase
  endfunction

  function automatic void load_flags(input logic [7:0] v);
    flag_z = (v == 8'h00);
    flag_n = v[7];
  endfunction

  function automatic void put_loaded(input logic [3:0] op, input logic [7:0] v);
    if (op == OP_LDA) reg_a = v;
    else if (op == OP_LDX) reg_x = v;
    else reg_y = v;
    load_flags(v);
  endfunction

  function automatic logic [15:0] index_abs(input logic [15:0] base, input logic [7:0] idx);
    logic [15:0] sum;
    sum = base + {8'h00, idx};
    extra_tick = ((base & PAGE_MASK) != (sum & PAGE_MASK)) || held_op == OP_STA;
    return sum;
  endfunction

  // last access of an instruction: a load reads, a store writes and completes
  function automatic void issue_access(input logic [15:0] ea, inout report_t r);
    r.bus_address = ea;
    if (held_op <= OP_LDY) begin
      r.bus_action = BUS_READ;
      seq_phase = PH_LOAD;
    end else begin
      r.bus_action = BUS_WRITE;
      r.bus_write_data = (held_op == OP_STA) ? reg_a : (held_op == OP_STX) ? reg_x : reg_y;
      r.instruction_done = 1'b1;
      r.ticks_used = cycle_count(held_mode, extra_tick);
      seq_phase = PH_IDLE;
    end
  endfunction

  function automatic report_t run_instruction_step(input step_t s);
    report_t     r;
    logic [15:0] base;
    logic [7:0]  zp_addr;
    r = '0;
    base = {s.operand_high, s.operand_low};
    if (s.command == CMD_START) begin
      seq_phase = PH_IDLE;
      extra_tick = 1'b0;
      if (!legal_pair(s.operation, s.address_mode)) begin
        r.instruction_done = 1'b1;
      end else begin
        held_op = s.operation;
        held_mode = s.address_mode;
        case (s.address_mode)
          MODE_IMP: begin
            case (s.operation)
              OP_TAX: begin reg_x = reg_a; load_flags(reg_x); end
              OP_TXA: begin reg_a = reg_x; load_flags(reg_a); end
              OP_TAY: begin reg_y = reg_a; load_flags(reg_y); end
              OP_TYA: begin reg_a = reg_y; load_flags(reg_a); end
              OP_TSX: begin reg_x = reg_s; load_flags(reg_x); end
              default: reg_s = reg_x;
            endcase
            r.instruction_done = 1'b1;
            r.ticks_used = 3'd1;
          end
          MODE_IMM: begin
            put_loaded(s.operation, s.operand_low);
            r.instruction_done = 1'b1;
            r.ticks_used = 3'd1;
          end
          MODE_ZP: issue_access({8'h00, s.operand_low}, r);
          MODE_ZPX: begin
            zp_addr = s.operand_low + reg_x;
            issue_access({8'h00, zp_addr}, r);
          end
          MODE_ZPY: begin
            zp_addr = s.operand_low + reg_y;
            issue_access({8'h00, zp_addr}, r);
          end
          MODE_ABS:  issue_access(base, r);
          MODE_ABSX: issue_access(index_abs(base, reg_x), r);
          MODE_ABSY: issue_access(index_abs(base, reg_y), r);
          default: begin
            ptr_addr = (s.address_mode == MODE_INDX) ? s.operand_low + reg_x : s.operand_low;
            r.bus_action = BUS_READ;
            r.bus_address = {8'h00, ptr_addr};
            seq_phase = PH_PTR_LO;
          end
        endcase
      end
    end else begin
      case (seq_phase)
        PH_PTR_LO: begin
          ptr_low = s.read_data;
          ptr_addr = ptr_addr + 8'd1;
          r.bus_action = BUS_READ;
          r.bus_address = {8'h00, ptr_addr};
          seq_phase = PH_PTR_HI;
        end
        PH_PTR_HI: begin
          base = {s.read_data, ptr_low};
          if (held_mode == MODE_INDY) base = index_abs(base, reg_y);
          issue_access(base, r);
        end
        PH_LOAD: begin
          put_loaded(held_op, s.read_data);
          r.instruction_done = 1'b1;
          r.ticks_used = cycle_count(held_mode, extra_tick);
          seq_phase = PH_IDLE;
        end
        default: ;
      endcase
    end
    r.accumulator_out = reg_a;
    r.x_out = reg_x;
    r.y_out = reg_y;
    r.stack_out = reg_s;
    r.zero_out = flag_z;
    r.negative_out = flag_n;
    return r;
  endfunction

  function automatic string describe(input report_t r);
    return $sformatf("bus=%0d addr=%h wdata=%h done=%b ticks=%0d a=%h x=%h y=%h s=%h z=%b n=%b",
                     r.bus_action, r.bus_address, r.bus_write_data, r.instruction_done,
                     r.ticks_used, r.accumulator_out, r.x_out, r.y_out, r.stack_out,
                     r.zero_out, r.negative_out);
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] corner[4] = '{8'h00, 8'h7F, 8'h80, 8'hFF};
    if ($urandom_range(0, 7) == 0) return corner[2'($urandom_range(0, 3))];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_start(input logic [3:0] op, input logic [3:0] mode,
                           input logic [7:0] lo, input logic [7:0] hi);
    step_t s;
    s.command = CMD_START;
    s.operation = op;
    s.address_mode = mode;
    s.operand_low = lo;
    s.operand_high = hi;
    s.read_data = 8'($urandom_range(0, 255));
    pending_steps.push_back(s);
    owed_bytes = data_needed(op, mode);
    useful_items++;
  endtask

  task automatic add_data(input logic [7:0] d);
    step_t s;
    s.command = CMD_DATA;
    s.operation = 4'($urandom_range(0, 15));
    s.address_mode = 4'($urandom_range(0, 15));
    s.operand_low = 8'($urandom_range(0, 255));
    s.operand_high = 8'($urandom_range(0, 255));
    s.read_data = d;
    pending_steps.push_back(s);
    if (owed_bytes > 0) begin
      owed_bytes--;
      useful_items++;
    end
  endtask

  task automatic add_instruction(input bit cut_short);
    logic [3:0] op, mode;
    int         n;
    do begin
      op = 4'($urandom_range(0, 11));
      mode = 4'($urandom_range(0, 9));
    end while (!legal_pair(op, mode));
    add_start(op, mode, pick_byte(), pick_byte());
    n = owed_bytes;
    if (cut_short && n > 0) n = $urandom_range(0, n - 1);
    repeat (n) add_data(pick_byte());
  endtask

  // driver and prediction at the point of acceptance
  always @(posedge clk) begin
    if (rst) begin
      step_ch.valid <= 1'b0;
      {reg_a, reg_x, reg_y, reg_s} = '0;
      {flag_z, flag_n} = '0;
      seq_phase = PH_IDLE;
      {held_op, held_mode, ptr_addr, ptr_low} = '0;
      extra_tick = 1'b0;
      send_gap = 0;
    end else begin
      if (step_ch.valid && step_ch.ready) begin
        expected_reports.push_back(run_instruction_step(on_bus));
        steps_taken++;
      end
      if (!step_ch.valid || step_ch.ready) begin
        if (send_gap > 0 || pending_steps.size() == 0) begin
          step_ch.valid <= 1'b0;
          if (send_gap > 0) send_gap--;
        end else begin
          on_bus = pending_steps.pop_front();
          step_ch.valid <= 1'b1;
          step_ch.command <= on_bus.command;
          step_ch.operation <= on_bus.operation;
          step_ch.address_mode <= on_bus.address_mode;
          step_ch.operand_low <= on_bus.operand_low;
          step_ch.operand_high <= on_bus.operand_high;
          step_ch.read_data <= on_bus.read_data;
          if (pending_steps.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
            send_gap = $urandom_range(1, 11);
        end
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    if (rst) begin
      report_ch.ready <= 1'b0;
      hold_gap = 0;
    end else begin
      if (report_ch.valid && report_ch.ready) begin
        got.bus_action = report_ch.bus_action;
        got.bus_address = report_ch.bus_address;
        got.bus_write_data = report_ch.bus_write_data;
        got.instruction_done = report_ch.instruction_done;
        got.ticks_used = report_ch.ticks_used;
        got.accumulator_out = report_ch.accumulator_out;
        got.x_out = report_ch.x_out;
        got.y_out = report_ch.y_out;
        got.stack_out = report_ch.stack_out;
        got.zero_out = report_ch.zero_out;
        got.negative_out = report_ch.negative_out;
        if (expected_reports.size() == 0) begin
          failures++;
          if (failures <= 10) $display("unexpected item: %s", describe(got));
        end else begin
          want = expected_reports.pop_front();
          if (got !== want) begin
            failures++;
            if (failures <= 10) begin
              $display("mismatch at %0t", $time);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
          end
        end
      end
      if (hold_gap > 0) begin
        report_ch.ready <= 1'b0;
        hold_gap--;
      end else begin
        report_ch.ready <= 1'b1;
        if (pending_steps.size() > QUIET_TAIL && $urandom_range(0, 7) == 0)
          hold_gap = $urandom_range(1, 11);
      end
    end
  end

  always @(posedge clk) begin
    if ((step_ch.valid && step_ch.ready) || (report_ch.valid && report_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int pick;
    step_ch.valid = 1'b0;
    step_ch.command = CMD_START;
    step_ch.operation = OP_LDA;
    step_ch.address_mode = MODE_IMP;
    step_ch.operand_low = '0;
    step_ch.operand_high = '0;
    step_ch.read_data = '0;
    report_ch.ready = 1'b0;
    quiet_cycles = 0;
    steps_taken = 0;
    failures = 0;
    owed_bytes = 0;

    // flags on zero and negative, every transfer, stack pointer move keeps flags
    add_start(OP_LDA, MODE_IMM, 8'h00, 8'h00);
    add_start(OP_LDX, MODE_IMM, 8'hFF, 8'h00);
    add_start(OP_LDY, MODE_IMM, 8'h80, 8'h00);
    add_start(OP_TXS, MODE_IMP, 8'h00, 8'h00);
    add_start(OP_TAY, MODE_IMP, 8'h00, 8'h00);
    add_start(OP_TSX, MODE_IMP, 8'h00, 8'h00);
    add_start(OP_TYA, MODE_IMP, 8'h00, 8'h00);
    add_start(OP_TXA, MODE_IMP, 8'h00, 8'h00);
    add_start(OP_TAX, MODE_IMP, 8'h00, 8'h00);
    // zero page index wrap, page cross, 16-bit wrap
    add_start(OP_STY, MODE_ZPX, 8'h80, 8'h00);
    add_start(OP_LDA, MODE_ABSX, 8'hFF, 8'h12);
    add_data(8'h00);
    add_start(OP_LDY, MODE_ABSX, 8'hF0, 8'hFF);
    add_data(8'h7F);
    add_start(OP_STX, MODE_ZPY, 8'h90, 8'h00);
    // pointer fetch wrapping within page zero
    add_start(OP_LDA, MODE_INDX, 8'h00, 8'h00);
    add_data(8'h34);
    add_data(8'h12);
    add_data(8'h80);
    add_start(OP_STA, MODE_INDY, 8'hFF, 8'h00);
    add_data(8'hF0);
    add_data(8'hFF);
    // abandoned instruction, unsupported pair, stray data while idle
    add_start(OP_LDY, MODE_ZPX, 8'h10, 8'h00);
    add_start(4'hF, 4'hF, 8'hFF, 8'hFF);
    add_data(8'hAA);
    add_start(OP_STY, MODE_ABS, 8'h00, 8'h00);

    useful_items = 0;
    while (useful_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) add_instruction(1'b0);
      else if (pick < 88) add_instruction(1'b1);
      else if (pick < 94) add_start(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                                    pick_byte(), pick_byte());
      else add_data(pick_byte());
    end
    steps_planned = pending_steps.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (steps_taken < steps_planned || expected_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0 && expected_reports.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[cpu6502_load_store_transfer.f]
sv/cpuls_pkg.sv
sv/cpuls_if.sv
sv/cpuls_exec.sv
sv/cpuls_regs.sv
sv/cpu6502_load_store_transfer.sv
test/tb_cpu6502_load_store_transfer.sv
